[rtl/jpeg_exif_segment_locator_macros.svh]
// Assertion macros for the locator checker.
`ifndef JPEG_EXIF_SEGMENT_LOCATOR_MACROS_SVH
`define JPEG_EXIF_SEGMENT_LOCATOR_MACROS_SVH

// Clocked check, quiet while reset is asserted.
`define JESL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define JESL_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/jesl_pkg.sv]
// Shared types, constants and helpers for the JPEG Exif segment locator.
package jesl_pkg;

	localparam int OFFSET_BITS = 32;
	localparam int CMP_W = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 1;

	typedef logic [OFFSET_BITS-1:0] ofs_t;
	typedef logic [CMP_W-1:0] cmp_t;

	localparam logic [1:0] ACT_NOT_JPEG = 2'd0;
	localparam logic [1:0] ACT_INSERT   = 2'd1;
	localparam logic [1:0] ACT_REPLACE  = 2'd2;

	localparam logic [7:0] MK_FILL = 8'hFF;
	localparam logic [7:0] MK_SOI  = 8'hD8;
	localparam logic [7:0] MK_SOS  = 8'hDA;
	localparam logic [7:0] MK_EOI  = 8'hD9;
	localparam logic [7:0] MK_TEM  = 8'h01;
	localparam logic [7:0] MK_RST0 = 8'hD0;
	localparam logic [7:0] MK_RST7 = 8'hD7;
	localparam logic [7:0] MK_APP1 = 8'hE1;
	localparam logic [7:0] MK_APP0 = 8'hE0;

	localparam logic [2:0] TAG_LEN = 3'd6;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] start_offset;
		logic [31:0] end_offset;
	} verdict_t;

	// Expected payload prefix of an Exif APP1 segment.
	function automatic logic [7:0] exif_tag(input logic [2:0] idx);
		logic [7:0] v;
		unique case (idx)
			3'd0: v = 8'h45;
			3'd1: v = 8'h78;
			3'd2: v = 8'h69;
			3'd3: v = 8'h66;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	function automatic cmp_t ext_ofs(input ofs_t v);
		return cmp_t'(v);
	endfunction

	function automatic cmp_t ext_len(input logic [31:0] v);
		return cmp_t'(v);
	endfunction

	function automatic logic [31:0] ofs_out(input ofs_t v);
		logic [63:0] w;
		w = 64'(v);
		return w[31:0];
	endfunction

endpackage

[rtl/jesl_parser.sv]
// Marker segment walker: per-byte state update and verdict.
module jesl_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	input  logic [31:0]         file_length,
	output jesl_pkg::verdict_t  verdict
);

	localparam logic [3:0] PH_SOI0   = 4'd0;
	localparam logic [3:0] PH_SOI1   = 4'd1;
	localparam logic [3:0] PH_TOP    = 4'd2;
	localparam logic [3:0] PH_FILL   = 4'd3;
	localparam logic [3:0] PH_LENHI  = 4'd4;
	localparam logic [3:0] PH_LENLO  = 4'd5;
	localparam logic [3:0] PH_PREFIX = 4'd6;
	localparam logic [3:0] PH_SKIP   = 4'd7;
	localparam logic [3:0] PH_HOLD   = 4'd8;

	jesl_pkg::ofs_t byte_offset_q, seg_start_q, seg_end_q, insert_q;
	logic [3:0]     phase_q;
	logic [7:0]     marker_q, len_hi_q;
	logic [2:0]     prefix_q;
	logic [1:0]     act_q;
	logic           done_q;

	jesl_pkg::ofs_t n_start, n_end, n_insert, o, nx, pos, pos_end;
	logic [3:0]     n_phase;
	logic [7:0]     n_marker, n_len_hi;
	logic [2:0]     n_prefix;
	logic [1:0]     n_act, fin_act;
	logic           n_done;
	logic [15:0]    seg_len;
	jesl_pkg::cmp_t fl;

	assign o       = byte_offset_q;
	assign nx      = o + jesl_pkg::ofs_t'(1);
	assign pos     = o - jesl_pkg::ofs_t'(1);
	assign seg_len = {len_hi_q, data_byte};
	assign pos_end = pos + jesl_pkg::ofs_t'(seg_len);
	assign fl      = jesl_pkg::ext_len(file_length);

	// Fewer than four bytes left at a segment start.
	function automatic logic top_fail(input jesl_pkg::ofs_t p, input jesl_pkg::cmp_t f);
		return (jesl_pkg::ext_ofs(p) + jesl_pkg::cmp_t'(4)) > f;
	endfunction

	always_comb begin
		n_phase  = phase_q;
		n_marker = marker_q;
		n_len_hi = len_hi_q;
		n_start  = seg_start_q;
		n_end    = seg_end_q;
		n_insert = insert_q;
		n_prefix = prefix_q;
		n_act    = act_q;
		n_done   = done_q;
		unique case (phase_q)
			PH_SOI0: begin
				if (data_byte != jesl_pkg::MK_FILL) begin
					n_act = jesl_pkg::ACT_NOT_JPEG; n_done = 1'b1; n_phase = PH_HOLD;
				end else begin
					n_phase = PH_SOI1;
				end
			end
			PH_SOI1: begin
				if (data_byte != jesl_pkg::MK_SOI || file_length < 32'd2) begin
					n_act = jesl_pkg::ACT_NOT_JPEG; n_done = 1'b1; n_phase = PH_HOLD;
				end else begin
					n_insert = jesl_pkg::ofs_t'(2);
					if (top_fail(nx, fl)) begin
						n_act = jesl_pkg::ACT_INSERT; n_done = 1'b1; n_phase = PH_HOLD;
					end else begin
						n_phase = PH_TOP;
					end
				end
			end
			PH_TOP: begin
				if (data_byte != jesl_pkg::MK_FILL || jesl_pkg::ext_ofs(nx) >= fl) begin
					n_act = jesl_pkg::ACT_INSERT; n_done = 1'b1; n_phase = PH_HOLD;
				end else begin
					n_phase = PH_FILL;
				end
			end
			PH_FILL: begin
				if (data_byte == jesl_pkg::MK_FILL) begin
					if (jesl_pkg::ext_ofs(nx) >= fl) begin
						n_act = jesl_pkg::ACT_INSERT; n_done = 1'b1; n_phase = PH_HOLD;
					end
				end else begin
					n_marker = data_byte;
					if (data_byte == jesl_pkg::MK_SOS || data_byte == jesl_pkg::MK_EOI) begin
						n_insert = pos;
						n_act = jesl_pkg::ACT_INSERT; n_done = 1'b1; n_phase = PH_HOLD;
					end else if (data_byte == jesl_pkg::MK_TEM ||
						(data_byte >= jesl_pkg::MK_RST0 && data_byte <= jesl_pkg::MK_RST7)) begin
						n_insert = nx;
						if (top_fail(nx, fl)) begin
							n_act = jesl_pkg::ACT_INSERT; n_done = 1'b1; n_phase = PH_HOLD;
						end else begin
							n_phase = PH_TOP;
						end
					end else if ((jesl_pkg::ext_ofs(nx) + jesl_pkg::cmp_t'(2)) > fl) begin
						n_act = jesl_pkg::ACT_INSERT; n_done = 1'b1; n_phase = PH_HOLD;
					end else begin
						n_phase = PH_LENHI;
					end
				end
			end
			PH_LENHI: begin
				n_len_hi = data_byte;
				n_phase  = PH_LENLO;
			end
			PH_LENLO: begin
				if (seg_len < 16'd2 ||
					(jesl_pkg::ext_ofs(pos) + jesl_pkg::cmp_t'(seg_len)) > fl) begin
					n_act = jesl_pkg::ACT_INSERT; n_done = 1'b1; n_phase = PH_HOLD;
				end else begin
					n_start = pos - jesl_pkg::ofs_t'(2);
					n_end   = pos_end;
					if (marker_q == jesl_pkg::MK_APP1 && seg_len >= 16'd8) begin
						n_prefix = 3'd0;
						n_phase  = PH_PREFIX;
					end else begin
						// Slide the insert point past a leading APP0 segment.
						if (marker_q == jesl_pkg::MK_APP0 && insert_q == n_start)
							n_insert = pos_end;
						if (seg_len == 16'd2) begin
							if (top_fail(pos_end, fl)) begin
								n_act = jesl_pkg::ACT_INSERT; n_done = 1'b1; n_phase = PH_HOLD;
							end else begin
								n_phase = PH_TOP;
							end
						end else begin
							n_phase = PH_SKIP;
						end
					end
				end
			end
			PH_PREFIX, PH_SKIP: begin
				if (phase_q == PH_PREFIX && data_byte == jesl_pkg::exif_tag(prefix_q)) begin
					n_prefix = prefix_q + 3'd1;
					if (n_prefix >= jesl_pkg::TAG_LEN) begin
						n_act = jesl_pkg::ACT_REPLACE; n_done = 1'b1; n_phase = PH_HOLD;
					end
				end else if (nx == seg_end_q) begin
					if (top_fail(nx, fl)) begin
						n_act = jesl_pkg::ACT_INSERT; n_done = 1'b1; n_phase = PH_HOLD;
					end else begin
						n_phase = PH_TOP;
					end
				end else begin
					n_phase = PH_SKIP;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		if (n_done)
			fin_act = n_act;
		else if (n_phase == PH_SOI0 || n_phase == PH_SOI1)
			fin_act = jesl_pkg::ACT_NOT_JPEG;
		else
			fin_act = jesl_pkg::ACT_INSERT;
		verdict.action = fin_act;
		unique case (fin_act)
			jesl_pkg::ACT_INSERT: begin
				verdict.start_offset = jesl_pkg::ofs_out(n_insert);
				verdict.end_offset   = jesl_pkg::ofs_out(n_insert);
			end
			jesl_pkg::ACT_REPLACE: begin
				verdict.start_offset = jesl_pkg::ofs_out(n_start);
				verdict.end_offset   = jesl_pkg::ofs_out(n_end);
			end
			default: begin
				verdict.start_offset = 32'd0;
				verdict.end_offset   = 32'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_offset_q <= '0;
			phase_q       <= PH_SOI0;
			marker_q      <= '0;
			len_hi_q      <= '0;
			seg_start_q   <= '0;
			seg_end_q     <= '0;
			insert_q      <= jesl_pkg::ofs_t'(2);
			prefix_q      <= '0;
			act_q         <= '0;
			done_q        <= 1'b0;
		end else if (step) begin
			if (last_byte) begin
				byte_offset_q <= '0;
				phase_q       <= PH_SOI0;
				marker_q      <= '0;
				len_hi_q      <= '0;
				seg_start_q   <= '0;
				seg_end_q     <= '0;
				insert_q      <= jesl_pkg::ofs_t'(2);
				prefix_q      <= '0;
				act_q         <= '0;
				done_q        <= 1'b0;
			end else begin
				byte_offset_q <= nx;
				phase_q       <= n_phase;
				marker_q      <= n_marker;
				len_hi_q      <= n_len_hi;
				seg_start_q   <= n_start;
				seg_end_q     <= n_end;
				insert_q      <= n_insert;
				prefix_q      <= n_prefix;
				act_q         <= n_act;
				done_q        <= n_done;
			end
		end
	end

endmodule

[rtl/jpeg_exif_segment_locator.sv]
// Top level of the JPEG Exif segment locator: stream ports, input and result registers.
// The last byte moves from the input register to the walker; the result register drives m_tvalid.
// Throughput: one byte per cycle; the only stall is a last byte meeting a full result register.
// Each byte is one pass of compares and a 33-bit add, so the walk never holds the stream.
// Reset (arst_n low, asynchronous): walker back to start-of-image, file_length to 0,
// both stream registers empty.
module jpeg_exif_segment_locator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,    // file_length
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,        // [7:0] data_byte
	input  logic        s_tlast,        // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [1:0]  m_tuser,        // [1:0] action
	output logic [63:0] m_tdata         // [31:0] start_offset, [63:32] end_offset
);

	logic               s1_valid_q;
	logic [7:0]         data_s1;
	logic               last_s1;
	logic               advance;
	logic [31:0]        file_length_q;
	logic               out_valid_q;
	jesl_pkg::verdict_t verdict;
	jesl_pkg::verdict_t result_q;

	// Hold the file size for bound checks; user only changes it between files (unenforced).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q <= '0;
		end else if (cfg_wr_en) begin
			file_length_q <= cfg_wr_data;
		end
	end

	// Advance the registered byte into the walker unless it is the last byte of a
	// file and the previous verdict is still waiting on the output side.
	assign advance  = s1_valid_q && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Input payload register: no reset needed, qualified by s1_valid_q.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	jesl_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.data_byte   (data_s1),
		.last_byte   (last_s1),
		.file_length (file_length_q),
		.verdict     (verdict)
	);

	// Result register: load the verdict on the last byte, drop it once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			result_q <= verdict;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = result_q.action;
	assign m_tdata  = {result_q.end_offset, result_q.start_offset};

endmodule

[rtl/jesl_checker.sv]
// Port-level checks on the locator's result stream, bound to the top level.
`include "jpeg_exif_segment_locator_macros.svh"

module jesl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [1:0]  m_tuser,
	input logic [63:0] m_tdata
);

	logic        stalled;
	logic        is_not_jpeg;
	logic        is_insert;
	logic        is_replace;
	logic        ofs_same;
	logic [65:0] out_word;

	assign stalled     = m_tvalid && !m_tready;
	assign is_not_jpeg = (m_tuser == jesl_pkg::ACT_NOT_JPEG);
	assign is_insert   = (m_tuser == jesl_pkg::ACT_INSERT);
	assign is_replace  = (m_tuser == jesl_pkg::ACT_REPLACE);
	assign ofs_same    = (m_tdata[31:0] == m_tdata[63:32]);
	assign out_word    = {m_tuser, m_tdata};

	// The result register is empty at the edge after any cycle spent in reset.
	`JESL_ASSERT_ALWAYS(a_no_result_in_reset, !arst_n |=> !m_tvalid, "result valid after reset")
	`JESL_ASSERT(a_result_holds, stalled |=> m_tvalid && $stable(out_word), "stalled result moved")
	`JESL_ASSERT(a_action_legal, m_tvalid |-> (is_not_jpeg || is_insert || is_replace), "bad action")
	`JESL_ASSERT(a_not_jpeg_zero, m_tvalid && is_not_jpeg |-> m_tdata == 64'd0, "offsets on not-JPEG")
	`JESL_ASSERT(a_insert_point, m_tvalid && is_insert |-> ofs_same, "insert offsets differ")

endmodule

bind jpeg_exif_segment_locator jesl_checker u_jesl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tuser  (m_tuser),
	.m_tdata  (m_tdata)
);

[verif/testbench.sv]
`timescale 1ns / 100ps
// Self-checking stream testbench for the JPEG Exif segment locator: directed and random files.
module testbench;

	// Walker phases of the local predictor.
	typedef enum logic [3:0] {
		WALK_SOI0,
		WALK_SOI1,
		WALK_TOP,
		WALK_FILL,
		WALK_LENHI,
		WALK_LENLO,
		WALK_PREFIX,
		WALK_SKIP,
		WALK_HOLD
	} walk_phase_t;

	localparam logic [47:0] EXIF_ID = 48'h0000_6669_7845;	// "Exif\0\0", first byte lowest
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 4;
	localparam int TIMEOUT_NS = 2_000_000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;	// [7:0] data_byte
	logic        s_tlast = 1'b0;	// last_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [1:0]  m_tuser;		// [1:0] action
	logic [63:0] m_tdata;		// [31:0] start_offset, [63:32] end_offset

	jpeg_exif_segment_locator u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tuser     (m_tuser),
		.m_tdata     (m_tdata)
	);

	always #2 clk = ~clk;

	// Predictor state: a private copy of the walker and of file_length.
	logic [63:0]        len_reg;
	logic [31:0]        pos;
	logic [31:0]        seg_start;
	logic [31:0]        seg_end;
	logic [31:0]        ins_ofs;
	logic [7:0]         marker;
	logic [15:0]        seg_len;
	logic [2:0]         tag_idx;
	logic [1:0]         dec_act;
	logic               dec_done;
	walk_phase_t        phase;
	jesl_pkg::verdict_t pending_verdicts[$];

	// Stimulus and bookkeeping.
	logic [7:0]         file_buf[$];
	int                 src_idle_pct = 0;
	int                 sink_idle_pct = 0;
	int                 hold_reqs = 0;
	int                 hold_seen = 0;
	int                 hold_left = 0;
	int                 errors = 0;
	int                 bytes_sent = 0;
	int                 files_sent = 0;
	int                 verdicts_checked = 0;
	int                 act_seen[4] = '{0, 0, 0, 0};
	jesl_pkg::verdict_t want_v;

	// Append one byte to the file under construction.
	function void add_byte(input logic [7:0] b);
		file_buf.insert(file_buf.size(), b);
	endfunction

	function void restart_walk();
		pos = '0;
		phase = WALK_SOI0;
		marker = '0;
		seg_len = '0;
		seg_start = '0;
		seg_end = '0;
		ins_ofs = 32'd2;
		tag_idx = '0;
		dec_act = jesl_pkg::ACT_NOT_JPEG;
		dec_done = 1'b0;
	endfunction

	function void decide(input logic [1:0] act);
		dec_act = act;
		dec_done = 1'b1;
		phase = WALK_HOLD;
	endfunction

	// Need at least four bytes left at a segment start.
	function void go_top(input logic [31:0] p);
		if (len_reg < 64'd4 || {32'b0, p} > len_reg - 64'd4)
			decide(jesl_pkg::ACT_INSERT);
		else
			phase = WALK_TOP;
	endfunction

	function void enter_fill(input logic [31:0] p);
		if ({32'b0, p} >= len_reg)
			decide(jesl_pkg::ACT_INSERT);
		else
			phase = WALK_FILL;
	endfunction

	function void after_payload(input logic [31:0] o);
		if (o + 32'd1 == seg_end)
			go_top(o + 32'd1);
		else
			phase = WALK_SKIP;
	endfunction

	// Advance the walk by one accepted byte; queue the verdict on the last byte of a file.
	function void walk_byte(input logic [7:0] b, input logic last);
		logic [31:0] o;
		logic [31:0] nx;
		logic [31:0] lpos;
		jesl_pkg::verdict_t v;
		o = pos;
		nx = pos + 32'd1;
		case (phase)
			WALK_SOI0: begin
				if (b != jesl_pkg::MK_FILL)
					decide(jesl_pkg::ACT_NOT_JPEG);
				else
					phase = WALK_SOI1;
			end
			WALK_SOI1: begin
				if (b != jesl_pkg::MK_SOI || len_reg < 64'd2) begin
					decide(jesl_pkg::ACT_NOT_JPEG);
				end else begin
					ins_ofs = 32'd2;
					go_top(nx);
				end
			end
			WALK_TOP: begin
				if (b != jesl_pkg::MK_FILL)
					decide(jesl_pkg::ACT_INSERT);
				else
					enter_fill(nx);
			end
			WALK_FILL: begin
				if (b == jesl_pkg::MK_FILL) begin
					enter_fill(nx);
				end else begin
					marker = b;
					if (b == jesl_pkg::MK_SOS || b == jesl_pkg::MK_EOI) begin
						ins_ofs = o - 32'd1;
						decide(jesl_pkg::ACT_INSERT);
					end else if (b == jesl_pkg::MK_TEM ||
					             (b >= jesl_pkg::MK_RST0 && b <= jesl_pkg::MK_RST7)) begin
						ins_ofs = nx;
						go_top(nx);
					end else if ({32'b0, nx} > len_reg || len_reg - {32'b0, nx} < 64'd2) begin
						decide(jesl_pkg::ACT_INSERT);
					end else begin
						phase = WALK_LENHI;
					end
				end
			end
			WALK_LENHI: begin
				seg_len = {b, 8'h00};
				phase = WALK_LENLO;
			end
			WALK_LENLO: begin
				lpos = o - 32'd1;
				seg_len = {seg_len[15:8], b};
				if (seg_len < 16'd2 || {32'b0, lpos} > len_reg ||
				    {48'b0, seg_len} > len_reg - {32'b0, lpos}) begin
					decide(jesl_pkg::ACT_INSERT);
				end else begin
					seg_start = lpos - 32'd2;
					seg_end = lpos + {16'b0, seg_len};
					if (marker == jesl_pkg::MK_APP1 && seg_len >= 16'd8) begin
						tag_idx = '0;
						phase = WALK_PREFIX;
					end else begin
						// A leading APP0 pushes the insert point past itself.
						if (marker == jesl_pkg::MK_APP0 && ins_ofs == seg_start)
							ins_ofs = seg_end;
						if (seg_len == 16'd2)
							go_top(seg_end);
						else
							phase = WALK_SKIP;
					end
				end
			end
			WALK_PREFIX: begin
				if (b == EXIF_ID[tag_idx*8 +: 8]) begin
					tag_idx = tag_idx + 3'd1;
					if (tag_idx >= jesl_pkg::TAG_LEN)
						decide(jesl_pkg::ACT_REPLACE);
				end else begin
					after_payload(o);
				end
			end
			WALK_SKIP: after_payload(o);
			default: ;
		endcase
		pos = nx;
		if (last) begin
			if (dec_done)
				v.action = dec_act;
			else if (phase == WALK_SOI0 || phase == WALK_SOI1)
				v.action = jesl_pkg::ACT_NOT_JPEG;
			else
				v.action = jesl_pkg::ACT_INSERT;
			v.start_offset = '0;
			v.end_offset = '0;
			if (v.action == jesl_pkg::ACT_INSERT) begin
				v.start_offset = ins_ofs;
				v.end_offset = ins_ofs;
			end else if (v.action == jesl_pkg::ACT_REPLACE) begin
				v.start_offset = seg_start;
				v.end_offset = seg_end;
			end
			pending_verdicts.insert(pending_verdicts.size(), v);
			restart_walk();
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
	                               input logic [31:0] want);
		errors++;
		$display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $time);
	endtask

	// Check every accepted verdict against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_verdicts.size() == 0) begin
				report_mismatch("verdict with none pending", {30'b0, m_tuser}, '0);
			end else begin
				want_v = pending_verdicts.pop_front();
				if (m_tuser != want_v.action)
					report_mismatch("action", {30'b0, m_tuser}, {30'b0, want_v.action});
				if (m_tdata[31:0] != want_v.start_offset)
					report_mismatch("start_offset", m_tdata[31:0], want_v.start_offset);
				if (m_tdata[63:32] != want_v.end_offset)
					report_mismatch("end_offset", m_tdata[63:32], want_v.end_offset);
				act_seen[want_v.action]++;
			end
			verdicts_checked++;
		end
	end

	// Result side: random stalls, plus a long hold-off whenever a test requests one.
	always @(negedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// Offer one byte, with random gaps first; return at the falling edge after the handshake.
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		walk_byte(b, last);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Drop the request and let every pending verdict arrive before touching the register.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_file_length(input logic [31:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		len_reg = {32'b0, v};
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Send file_buf as one file; rewrite file_length only when it changes.
	task automatic send_file(input logic [31:0] flen);
		if ({32'b0, flen} != len_reg) begin
			wait_drained();
			write_file_length(flen);
		end
		foreach (file_buf[i])
			send_byte(file_buf[i], i == file_buf.size() - 1);
		files_sent++;
	endtask

	task automatic send_exact();
		send_file(32'(file_buf.size()));
	endtask

	task automatic set_idling(input int src_pct, input int sink_pct);
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
	endtask

	// Append FF, marker, big-endian length and up to 20 payload bytes.
	task automatic push_seg(input logic [7:0] mk, input logic [15:0] len, input bit with_tag);
		int n;
		n = (len < 16'd2) ? 0 : int'(len) - 2;
		if (n > 20)
			n = 20;
		add_byte(jesl_pkg::MK_FILL);
		add_byte(mk);
		add_byte(len[15:8]);
		add_byte(len[7:0]);
		for (int i = 0; i < n; i++)
			add_byte((with_tag && i < 6) ? EXIF_ID[i*8 +: 8] : 8'($urandom));
	endtask

	// Mostly well-formed files with random content; some garbage, broken or mislabeled ones.
	task automatic build_random_file(output logic [31:0] flen);
		int sz;
		int at;
		logic [7:0] mk;
		file_buf.delete();
		if ($urandom_range(19) == 0) begin
			repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
			if ($urandom_range(2) == 0)
				file_buf[0] = jesl_pkg::MK_FILL;
		end else begin
			add_byte(jesl_pkg::MK_FILL);
			add_byte(($urandom_range(19) == 0) ? 8'($urandom) : jesl_pkg::MK_SOI);
			repeat ($urandom_range(5)) begin
				if ($urandom_range(3) == 0)
					repeat ($urandom_range(1, 2)) add_byte(jesl_pkg::MK_FILL);
				case ($urandom_range(9))
					0, 1: push_seg(jesl_pkg::MK_APP0, 16'($urandom_range(2, 8)), 1'b0);
					2, 3: push_seg(jesl_pkg::MK_APP1, 16'($urandom_range(8, 14)), 1'b1);
					4: begin
						// Exif prefix with one bit flipped
						at = file_buf.size();
						push_seg(jesl_pkg::MK_APP1, 16'($urandom_range(8, 12)), 1'b1);
						file_buf[at + 4 + $urandom_range(5)] ^= 8'(1 << $urandom_range(7));
					end
					5: push_seg(jesl_pkg::MK_APP1, 16'($urandom_range(2, 7)), 1'b1);
					6: begin
						mk = ($urandom_range(8) == 8) ? jesl_pkg::MK_TEM :
						     8'(jesl_pkg::MK_RST0 + $urandom_range(7));
						add_byte(jesl_pkg::MK_FILL);
						add_byte(mk);
					end
					7: push_seg(8'($urandom_range(8'hC0, 8'hFE)), 16'($urandom_range(2, 10)),
					            1'b0);
					8: push_seg(8'($urandom_range(8'hC0, 8'hEF)),
					            ($urandom_range(1) == 0) ? 16'($urandom_range(1)) : 16'($urandom),
					            1'b0);
					default: add_byte(8'($urandom));
				endcase
			end
			case ($urandom_range(3))
				0: begin
					add_byte(jesl_pkg::MK_FILL);
					add_byte(jesl_pkg::MK_SOS);
					repeat ($urandom_range(4)) add_byte(8'($urandom));
				end
				1: begin
					add_byte(jesl_pkg::MK_FILL);
					add_byte(jesl_pkg::MK_EOI);
				end
				2: ;
				default: repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
			endcase
		end
		sz = file_buf.size();
		if ($urandom_range(9) == 0)
			file_buf[$urandom_range(sz - 1)] = 8'($urandom);
		case ($urandom_range(9))
			7: flen = 32'(sz + int'($urandom_range(6)) - 3);
			8: flen = 32'($urandom_range(0, sz + 4));
			9: flen = 32'($urandom);
			default: flen = 32'(sz);
		endcase
	endtask

	// Bad first bytes, short register, end before the start marker, extreme lengths.
	task automatic test_not_jpeg();
		file_buf = '{8'h00};
		send_file(32'd10);
		file_buf = '{8'hFF, 8'h00, 8'h12, 8'hFE};
		send_exact();
		file_buf = '{8'hFF};
		send_exact();
		file_buf = '{8'hFF, 8'hD8};
		send_file(32'd1);
		send_file(32'd0);
	endtask

	// Exif APP1 behind an APP0 and fill bytes; bytes after the verdict are ignored.
	task automatic test_exif_replace();
		file_buf = '{8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h04, 8'hA5, 8'h5A,
		             8'hFF, 8'hFF, 8'hE1, 8'h00, 8'h0A, 8'h45, 8'h78, 8'h69,
		             8'h66, 8'h00, 8'h00, 8'hC3, 8'h3C, 8'hFF, 8'hD9};
		send_exact();
		// Decide on the very last byte.
		file_buf = '{8'hFF, 8'hD8, 8'hFF, 8'hE1, 8'h00, 8'h08,
		             8'h45, 8'h78, 8'h69, 8'h66, 8'h00, 8'h00};
		send_exact();
	endtask

	// Insert after start marker, at SOS past APP0 and restart markers, on a mid-payload end.
	task automatic test_insert_points();
		file_buf = '{8'hFF, 8'hD8, 8'hFF, 8'hD9};
		send_exact();
		file_buf = '{8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h02, 8'hFF, 8'hD0,
		             8'hFF, 8'h01, 8'hFF, 8'hE0, 8'h00, 8'h03, 8'h55, 8'hFF,
		             8'hC0, 8'h00, 8'h03, 8'h77, 8'hFF, 8'hDA, 8'h00};
		send_exact();
		// Register at its top value: the file ends mid-payload.
		file_buf = '{8'hFF, 8'hD8, 8'hFF, 8'hE2, 8'h00, 8'h08, 8'h11, 8'h22};
		send_file(32'hFFFF_FFFF);
	endtask

	// Each bound check stops the walk with an insert.
	task automatic test_bound_checks();
		file_buf = '{8'hFF, 8'hD8, 8'h12, 8'h34, 8'h56, 8'h78};
		send_exact();
		file_buf = '{8'hFF, 8'hD8, 8'hFF, 8'hC4, 8'h00, 8'h01, 8'h00, 8'h00};
		send_exact();
		file_buf = '{8'hFF, 8'hD8, 8'hFF, 8'hC4, 8'h00, 8'h40, 8'h00, 8'h00};
		send_exact();
		// Short APP1 walks like any segment.
		file_buf = '{8'hFF, 8'hD8, 8'hFF, 8'hE1, 8'h00, 8'h06, 8'h45, 8'h78,
		             8'h69, 8'h66, 8'hFF, 8'hDA, 8'h00};
		send_exact();
		file_buf = '{8'hFF, 8'hD8, 8'hFF, 8'hE1, 8'h00, 8'h08, 8'h45, 8'h78,
		             8'h00, 8'h66, 8'h00, 8'h00, 8'hFF, 8'hD9};
		send_exact();
		file_buf = '{8'hFF, 8'hD8, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_exact();
		file_buf = '{8'hFF, 8'hD8, 8'hFF, 8'hC0};
		send_file(32'd3);
		file_buf = '{8'hFF, 8'hD8, 8'hFF, 8'hC0, 8'h00};
		send_exact();
	endtask

	task automatic test_random_files(input int target);
		int goal;
		logic [31:0] flen;
		goal = bytes_sent + target;
		while (bytes_sent < goal) begin
			build_random_file(flen);
			send_file(flen);
		end
	endtask

	// Hold the result side off while tiny files keep coming, so the last byte stalls the input.
	task automatic test_backpressure();
		set_idling(0, 0);
		wait_drained();
		write_file_length(32'd2);
		hold_reqs++;
		repeat (24) begin
			case ($urandom_range(2))
				0: file_buf = '{8'hFF, 8'h00};
				1: file_buf = '{8'hFF, 8'hD8};
				default: file_buf = '{8'(($urandom)), 8'(($urandom))};
			endcase
			send_file(32'd2);
		end
		wait_drained();
	endtask

	initial begin
		restart_walk();
		len_reg = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_idling(38, 73);
		test_not_jpeg();
		test_exif_replace();
		test_insert_points();
		test_bound_checks();
		test_random_files(300);
		set_idling(73, 38);
		test_random_files(300);
		set_idling(0, 0);
		test_random_files(300);
		test_backpressure();
		wait_drained();
		repeat (10) @(posedge clk);

		$display("covered %0d files, %0d bytes, %0d verdicts checked", files_sent, bytes_sent,
		         verdicts_checked);
		$display("verdicts by kind: not jpeg %0d, insert %0d, replace %0d, errors %0d",
		         act_seen[0], act_seen[1], act_seen[2], errors);
		if (errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("timeout with %0d verdicts pending", pending_verdicts.size());
		$display("testbench: FAIL");
		$finish;
	end

endmodule
